### design/vhs_pkg.sv
package vhs_pkg;

  localparam int unsigned StackSlots = 8;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned PageW      = 16;

  localparam logic [3:0] REQ_REPLACE = 4'd0;
  localparam logic [3:0] REQ_PUSH    = 4'd1;
  localparam logic [3:0] REQ_POP     = 4'd2;
  localparam logic [3:0] REQ_RESET   = 4'd3;
  localparam logic [3:0] REQ_BACK    = 4'd4;
  localparam logic [3:0] REQ_COVER   = 4'd5;
  localparam logic [3:0] REQ_ADD     = 4'd6;
  localparam logic [3:0] REQ_PRIO    = 4'd7;
  localparam logic [3:0] REQ_DELETE  = 4'd8;
  localparam logic [3:0] REQ_READ    = 4'd9;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_JUMP  = 3'd1;
  localparam logic [2:0] ERR_MISS  = 3'd2;
  localparam logic [2:0] ERR_OVER  = 3'd3;
  localparam logic [2:0] ERR_UNDER = 3'd4;
  localparam logic [2:0] ERR_BAD   = 3'd5;

  // controller commands to the datapath
  typedef struct packed {
    logic             load;     // capture request
    logic             scan;     // compare one slot against page
    logic             shift;    // move slot idx+1 into idx (delete) or idx-1 into idx (insert)
    logic             shift_up; // 1: insert direction
    logic [IdxW-1:0]  idx;
    logic             commit;   // apply the simple update and finish
  } vhs_cmd_t;

  typedef struct packed {
    logic             match;    // slot idx holds page
    logic             del_go;   // delete by value will compact
    logic             ins_go;   // priority add will insert below the top
    logic [IdxW-1:0]  ins_idx;  // slot that takes the inserted page
    logic [IdxW-1:0]  depth;
  } vhs_sts_t;

endpackage

### design/vhs_datapath.sv
module vhs_datapath
  import vhs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vhs_cmd_t         cmd_i,
  input  logic [3:0]       req_type_i,
  input  logic [PageW-1:0] page_id_i,
  input  logic             keep_top_i,
  input  logic             jump_ok_i,
  input  logic [7:0]       outranks_mask_i,
  input  logic [IdxW-1:0]  read_index_i,
  output vhs_sts_t         sts_o,
  output logic             done_ok_o,
  output logic [2:0]       error_code_o,
  output logic [IdxW-1:0]  depth_o,
  output logic [PageW-1:0] top_page_o,
  output logic [PageW-1:0] below_top_page_o,
  output logic [PageW-1:0] read_page_o,
  output logic [PageW-1:0] read_history_o
);

  logic [PageW-1:0] stk_q [StackSlots];
  logic [PageW-1:0] hist_q [StackSlots];
  logic [IdxW-1:0]  dep_q, dep_d;
  logic [3:0]       typ_q;
  logic [PageW-1:0] pg_q;
  logic             keep_q, jok_q;
  logic [7:0]       mask_q;
  logic [IdxW-1:0]  ridx_q;
  logic [IdxW-1:0]  found_q;
  logic             fnd_q;

  // combinational decision for the committing request
  logic [2:0]       err;
  logic [IdxW-1:0]  top_i, bel_i, ins_i;
  logic             hist_en, ins_ok, do_ins, do_del;
  logic [PageW-1:0] hist_pg, top_pg;
  logic             top_out;

  assign top_i  = dep_q - 1'b1;
  assign bel_i  = dep_q - 2'd2;
  assign top_pg = stk_q[top_i];
  assign top_out = mask_q[top_i];

  // insert just above the highest slot below top not outranking (mask narrow, few steps)
  always_comb begin
    ins_i  = '0;
    ins_ok = 1'b0;
    for (int k = 0; k < StackSlots - 1; k++) begin
      if (k < int'(dep_q) && !mask_q[k]) begin
        ins_i  = IdxW'(k + 1);
        ins_ok = 1'b1;
      end
    end
  end

  always_comb begin
    err     = ERR_NONE;
    hist_en = 1'b0;
    hist_pg = pg_q;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    dep_d   = dep_q;
    if (typ_q > REQ_READ) begin
      err = ERR_BAD;
    end else if (pg_q == '0 && (typ_q <= REQ_RESET || typ_q == REQ_COVER ||
                 typ_q == REQ_ADD || typ_q == REQ_PRIO)) begin
      err = ERR_BAD;
    end else begin
      case (typ_q)
        REQ_REPLACE: if (dep_q == '0) err = ERR_UNDER; else hist_en = 1'b1;
        REQ_PUSH: begin
          if (dep_q == IdxW'(StackSlots - 1)) err = ERR_OVER;
          else begin dep_d = dep_q + 1'b1; hist_en = 1'b1; end
        end
        REQ_POP: begin
          if (dep_q == '0) err = ERR_UNDER;
          else if (top_pg != pg_q) err = ERR_MISS;
          else dep_d = top_i;
        end
        REQ_RESET: begin
          if (keep_q && dep_q == '0) err = ERR_UNDER;
          else if (!jok_q) err = ERR_JUMP;
          else begin
            hist_en = 1'b1;
            if (keep_q) begin dep_d = IdxW'(2); hist_pg = top_pg; end
            else dep_d = IdxW'(1);
          end
        end
        REQ_BACK: begin
          if (dep_q == '0) err = ERR_UNDER;
          else if (!fnd_q) err = ERR_MISS;
          else if (!jok_q) err = ERR_JUMP;
          else begin dep_d = found_q + 1'b1; hist_en = 1'b1; end
        end
        REQ_COVER: begin
          if (dep_q == '0) err = ERR_UNDER;
          else if (!jok_q) err = ERR_JUMP;
          else hist_en = 1'b1;
        end
        REQ_ADD, REQ_PRIO: begin
          if (dep_q == '0) err = ERR_UNDER;
          else if (dep_q == IdxW'(StackSlots - 1)) err = ERR_OVER;
          else if (typ_q == REQ_PRIO && top_out) begin
            if (!ins_ok) err = ERR_MISS;
            else begin do_ins = 1'b1; dep_d = dep_q + 1'b1; end
          end else if (!jok_q) err = ERR_JUMP;
          else begin
            dep_d = dep_q + 1'b1; hist_en = 1'b1;
            if (keep_q) hist_pg = top_pg;
          end
        end
        REQ_DELETE: begin
          if (dep_q == '0) err = ERR_UNDER;
          else if (pg_q != '0 && top_pg != pg_q) begin
            if (fnd_q) begin do_del = 1'b1; dep_d = top_i; end
          end else if (dep_q < IdxW'(2)) err = ERR_UNDER;
          else if (!jok_q) err = ERR_JUMP;
          else begin dep_d = top_i; hist_en = 1'b1; hist_pg = stk_q[bel_i]; end
        end
        default: err = ERR_NONE;
      endcase
    end
  end

  assign sts_o.match   = (stk_q[cmd_i.idx] == pg_q) && (cmd_i.idx < dep_q);
  assign sts_o.del_go  = do_del;
  assign sts_o.ins_go  = do_ins;
  assign sts_o.ins_idx = ins_i;
  assign sts_o.depth   = dep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dep_q <= '0;
      for (int k = 0; k < StackSlots; k++) hist_q[k] <= '0;
      fnd_q <= 1'b0;
      found_q <= '0;
      done_ok_o <= 1'b0;
      error_code_o <= ERR_NONE;
      depth_o <= '0;
    end else begin
      if (cmd_i.load) begin
        fnd_q <= 1'b0;
      end
      if (cmd_i.scan && sts_o.match && !fnd_q) begin
        fnd_q   <= 1'b1;
        found_q <= cmd_i.idx;
      end
      if (cmd_i.commit) begin
        dep_q <= dep_d;
        if (hist_en) begin
          for (int k = StackSlots - 1; k > 0; k--) hist_q[k] <= hist_q[k-1];
          hist_q[0] <= hist_pg;
        end
        done_ok_o    <= (err == ERR_NONE);
        error_code_o <= err;
        depth_o      <= dep_d;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      typ_q  <= req_type_i;
      pg_q   <= page_id_i;
      keep_q <= keep_top_i;
      jok_q  <= jump_ok_i;
      mask_q <= outranks_mask_i;
      ridx_q <= read_index_i;
    end
    if (cmd_i.shift) begin
      if (cmd_i.shift_up) stk_q[cmd_i.idx] <= stk_q[cmd_i.idx - 1'b1];
      else                stk_q[cmd_i.idx] <= stk_q[cmd_i.idx + 1'b1];
    end
    if (cmd_i.commit && err == ERR_NONE) begin
      case (typ_q)
        REQ_REPLACE, REQ_COVER: stk_q[top_i] <= pg_q;
        REQ_PUSH: stk_q[dep_q] <= pg_q;
        REQ_RESET: begin
          stk_q[0] <= pg_q;
          if (keep_q) stk_q[1] <= top_pg;
        end
        REQ_ADD, REQ_PRIO: begin
          if (do_ins) stk_q[ins_i] <= pg_q;
          else if (keep_q) begin
            stk_q[top_i] <= pg_q;
            stk_q[dep_q] <= top_pg;
          end else stk_q[dep_q] <= pg_q;
        end
        default: ;
      endcase
    end
  end

  // result view: read after the state update, so taken in the cycle after commit
  logic view_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) view_q <= 1'b0;
    else         view_q <= cmd_i.commit;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_page_o       <= '0;
      below_top_page_o <= '0;
      read_page_o      <= '0;
      read_history_o   <= '0;
    end else if (view_q) begin
      top_page_o       <= (dep_q >= IdxW'(1)) ? stk_q[top_i] : '0;
      below_top_page_o <= (dep_q >= IdxW'(2)) ? stk_q[bel_i] : '0;
      read_page_o      <= (typ_q == REQ_READ && ridx_q < dep_q) ? stk_q[ridx_q] : '0;
      read_history_o   <= (typ_q == REQ_READ) ? hist_q[ridx_q] : '0;
    end
  end

endmodule

### design/vhs_ctrl.sv
module vhs_ctrl
  import vhs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [3:0]      req_type_i,
  input  vhs_sts_t        sts_i,
  output vhs_cmd_t        cmd_o,
  output logic            busy_o,
  output logic            valid_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_PREP   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_VIEW   = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]      st_q, st_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            up_q, up_d;
  logic [IdxW-1:0] top;

  assign top = sts_i.depth - 1'b1;

  always_comb begin
    st_d  = st_q;
    idx_d = idx_q;
    up_d  = up_q;
    cmd_o = '0;
    cmd_o.idx = idx_q;
    cmd_o.shift_up = up_q;
    case (st_q)
      S_IDLE: if (start_i) begin
        cmd_o.load = 1'b1;
        idx_d = '0;
        st_d  = (req_type_i inside {REQ_BACK, REQ_DELETE}) ? S_SCAN : S_PREP;
      end
      S_SCAN: begin
        // walk slots from the bottom, stop at the first match
        cmd_o.scan = 1'b1;
        if (sts_i.match) st_d = S_PREP;
        else if (idx_q == IdxW'(StackSlots - 1)) st_d = S_PREP;
        else idx_d = idx_q + 1'b1;
      end
      S_PREP: begin
        // close the gap after a delete or open one for a priority add
        st_d = S_COMMIT;
        if (sts_i.del_go) begin
          up_d = 1'b0;
          st_d = S_SHIFT;
        end else if (sts_i.ins_go) begin
          up_d  = 1'b1;
          idx_d = sts_i.depth;
          st_d  = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (up_q) begin
          idx_d = idx_q - 1'b1;
          if (idx_q - 1'b1 == sts_i.ins_idx) st_d = S_COMMIT;
        end else begin
          idx_d = idx_q + 1'b1;
          if (idx_q + 1'b1 == top) st_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        st_d = S_VIEW;
      end
      S_VIEW: st_d = S_OUT;
      S_OUT:  st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  assign busy_o  = (st_q != S_IDLE);
  assign valid_o = (st_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; idx_q <= '0; up_q <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; up_q <= up_d;
    end
  end

`ifndef ASSERT_OFF
  a_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("double result");
  a_commit_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> st_q == S_VIEW) else $error("commit order");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("not busy");
`endif

endmodule

### design/view_history_stack.sv
// channel | dir | handshake      | fields
// request | in  | start_i/busy_o | req_type, page_id, keep_top, jump_ok, outranks_mask, read_index
// result  | out | valid_o strobe | done_ok .. read_history
// An accepted request passes through the prep, commit, view and output states;
// go back and delete first scan the slots from the bottom, and a delete compaction or a
// priority insert adds a shift step for each slot moved.
// Reset clears depth and history; stack slots are undefined until written.
// The result strobe lasts one cycle; the receiver cannot stall.
module view_history_stack
  import vhs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [3:0]       req_type_i,
  input  logic [PageW-1:0] page_id_i,
  input  logic             keep_top_i,
  input  logic             jump_ok_i,
  input  logic [7:0]       outranks_mask_i,
  input  logic [IdxW-1:0]  read_index_i,
  output logic             valid_o,
  output logic             done_ok_o,
  output logic [2:0]       error_code_o,
  output logic [IdxW-1:0]  depth_o,
  output logic [PageW-1:0] top_page_o,
  output logic [PageW-1:0] below_top_page_o,
  output logic [PageW-1:0] read_page_o,
  output logic [PageW-1:0] read_history_o
);

  vhs_cmd_t cmd;
  vhs_sts_t sts;

  vhs_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .req_type_i,
    .sts_i(sts), .cmd_o(cmd), .busy_o, .valid_o
  );

  vhs_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .req_type_i, .page_id_i, .keep_top_i, .jump_ok_i,
    .outranks_mask_i, .read_index_i, .sts_o(sts), .done_ok_o, .error_code_o,
    .depth_o, .top_page_o, .below_top_page_o, .read_page_o, .read_history_o
  );

endmodule

### test/view_history_checker.sv
`timescale 1ns / 100ps
module view_history_checker
  import vhs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [3:0]       req_type_i,
  input  logic [PageW-1:0] page_id_i,
  input  logic             keep_top_i,
  input  logic             jump_ok_i,
  input  logic [7:0]       outranks_mask_i,
  input  logic [IdxW-1:0]  read_index_i,
  input  logic             valid_i,
  input  logic             done_ok_i,
  input  logic [2:0]       error_code_i,
  input  logic [IdxW-1:0]  depth_i,
  input  logic [PageW-1:0] top_page_i,
  input  logic [PageW-1:0] below_top_page_i,
  input  logic [PageW-1:0] read_page_i,
  input  logic [PageW-1:0] read_history_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               results_o
);

  typedef struct packed {
    logic             done_ok;
    logic [2:0]       error_code;
    logic [IdxW-1:0]  depth;
    logic [PageW-1:0] top_page;
    logic [PageW-1:0] below_top_page;
    logic [PageW-1:0] read_page;
    logic [PageW-1:0] read_history;
  } outcome_t;

  logic [PageW-1:0] pages   [StackSlots];
  logic [PageW-1:0] shown   [StackSlots];
  int unsigned      depth_m;
  outcome_t         outcomes_q[$];

  function automatic void note_shown(logic [PageW-1:0] pg);
    for (int i = StackSlots - 1; i > 0; i--) shown[i] = shown[i-1];
    shown[0] = pg;
  endfunction

  function automatic logic [2:0] add_page(logic [PageW-1:0] pg, logic keep, logic jok);
    logic [PageW-1:0] old_top;
    if (depth_m == 0) return ERR_UNDER;
    if (depth_m + 1 > StackSlots - 1) return ERR_OVER;
    if (!jok) return ERR_JUMP;
    old_top = pages[depth_m-1];
    depth_m++;
    if (keep) begin
      pages[depth_m-2] = pg;
      pages[depth_m-1] = old_top;
      note_shown(old_top);
    end else begin
      pages[depth_m-1] = pg;
      note_shown(pg);
    end
    return ERR_NONE;
  endfunction

  function automatic logic [2:0] apply_request(logic [3:0] kind, logic [PageW-1:0] pg,
                                               logic keep, logic jok, logic [7:0] mask);
    int unsigned i;
    logic [PageW-1:0] old_top;
    if (kind > REQ_READ) return ERR_BAD;
    if (pg == 0 && (kind <= REQ_RESET || kind == REQ_COVER || kind == REQ_ADD ||
                    kind == REQ_PRIO)) return ERR_BAD;
    case (kind)
      REQ_REPLACE: begin
        if (depth_m == 0) return ERR_UNDER;
        pages[depth_m-1] = pg;
        note_shown(pg);
      end
      REQ_PUSH: begin
        if (depth_m + 1 > StackSlots - 1) return ERR_OVER;
        pages[depth_m] = pg;
        depth_m++;
        note_shown(pg);
      end
      REQ_POP: begin
        if (depth_m == 0) return ERR_UNDER;
        if (pages[depth_m-1] != pg) return ERR_MISS;
        depth_m--;
      end
      REQ_RESET: begin
        if (keep && depth_m == 0) return ERR_UNDER;
        if (!jok) return ERR_JUMP;
        if (keep) begin
          old_top = pages[depth_m-1];
          pages[0] = pg;
          pages[1] = old_top;
          depth_m = 2;
          note_shown(old_top);
        end else begin
          pages[0] = pg;
          depth_m = 1;
          note_shown(pg);
        end
      end
      REQ_BACK: begin
        if (depth_m == 0) return ERR_UNDER;
        for (i = 0; i < depth_m; i++) if (pages[i] == pg) break;
        if (i == depth_m) return ERR_MISS;
        if (!jok) return ERR_JUMP;
        depth_m = i + 1;
        note_shown(pg);
      end
      REQ_COVER: begin
        if (depth_m == 0) return ERR_UNDER;
        if (!jok) return ERR_JUMP;
        pages[depth_m-1] = pg;
        note_shown(pg);
      end
      REQ_ADD: return add_page(pg, keep, jok);
      REQ_PRIO: begin
        if (depth_m == 0) return ERR_UNDER;
        if (!mask[depth_m-1]) return add_page(pg, keep, jok);
        if (depth_m + 1 > StackSlots - 1) return ERR_OVER;
        for (i = depth_m; i > 0; i--) if (!mask[i-1]) break;
        if (i == 0) return ERR_MISS;
        for (int j = depth_m; j > i; j--) pages[j] = pages[j-1];
        pages[i] = pg;
        depth_m++;
      end
      REQ_DELETE: begin
        if (depth_m == 0) return ERR_UNDER;
        if (pg != 0 && pages[depth_m-1] != pg) begin
          for (i = 0; i < depth_m; i++) if (pages[i] == pg) break;
          if (i == depth_m) return ERR_NONE;
          while (i + 1 < depth_m) begin
            pages[i] = pages[i+1];
            i++;
          end
          depth_m--;
          return ERR_NONE;
        end
        if (depth_m < 2) return ERR_UNDER;
        if (!jok) return ERR_JUMP;
        depth_m--;
        note_shown(pages[depth_m-1]);
      end
      default: ;
    endcase
    return ERR_NONE;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want, got;
    if (!rst_ni) begin
      depth_m = 0;
      for (int i = 0; i < StackSlots; i++) begin
        shown[i] = '0;
        pages[i] = '0;
      end
      outcomes_q.delete();
      fail_count_o <= 0;
      results_o    <= 0;
    end else begin
      if (valid_i) begin
        got = '{done_ok_i, error_code_i, depth_i, top_page_i, below_top_page_i,
                read_page_i, read_history_i};
        results_o <= results_o + 1;
        if (outcomes_q.size() == 0) begin
          $error("result with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = outcomes_q.pop_front();
          if (got != want) fail_count_o <= fail_count_o + 1;
          if (got.done_ok != want.done_ok)
            $error("done_ok exp %0d got %0d", want.done_ok, got.done_ok);
          if (got.error_code != want.error_code)
            $error("error_code exp %0d got %0d", want.error_code, got.error_code);
          if (got.depth != want.depth)
            $error("depth exp %0d got %0d", want.depth, got.depth);
          if (got.top_page != want.top_page)
            $error("top_page exp %h got %h", want.top_page, got.top_page);
          if (got.below_top_page != want.below_top_page)
            $error("below_top_page exp %h got %h", want.below_top_page, got.below_top_page);
          if (got.read_page != want.read_page)
            $error("read_page exp %h got %h", want.read_page, got.read_page);
          if (got.read_history != want.read_history)
            $error("read_history exp %h got %h", want.read_history, got.read_history);
        end
      end
      if (start_i && !busy_i) begin
        want = '0;
        want.error_code = apply_request(req_type_i, page_id_i, keep_top_i, jump_ok_i,
                                        outranks_mask_i);
        want.done_ok = (want.error_code == ERR_NONE);
        want.depth   = depth_m[IdxW-1:0];
        if (depth_m >= 1) want.top_page = pages[depth_m-1];
        if (depth_m >= 2) want.below_top_page = pages[depth_m-2];
        if (req_type_i == REQ_READ) begin
          if (read_index_i < depth_m) want.read_page = pages[read_index_i];
          want.read_history = shown[read_index_i];
        end
        outcomes_q.push_back(want);
      end
    end
  end

  assign pending_o = outcomes_q.size();

endmodule

### test/view_history_stack_tb.sv
`timescale 1ns / 100ps
module view_history_stack_tb;
  import vhs_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic [3:0]       req_type_i = REQ_READ;
  logic [PageW-1:0] page_id_i = '0;
  logic             keep_top_i = 1'b0;
  logic             jump_ok_i = 1'b0;
  logic [7:0]       outranks_mask_i = '0;
  logic [IdxW-1:0]  read_index_i = '0;
  logic             valid_o, done_ok_o;
  logic [2:0]       error_code_o;
  logic [IdxW-1:0]  depth_o;
  logic [PageW-1:0] top_page_o, below_top_page_o, read_page_o, read_history_o;
  int               fail_count, pending, results;
  int               cycle_count = 0;
  int               requests_sent = 0;
  logic [PageW-1:0] recent_pages [8];

  localparam int CycleLimit = 400000;

  view_history_stack dut (.*);

  view_history_checker checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .req_type_i, .page_id_i, .keep_top_i,
    .jump_ok_i, .outranks_mask_i, .read_index_i, .valid_i(valid_o), .done_ok_i(done_ok_o),
    .error_code_i(error_code_o), .depth_i(depth_o), .top_page_i(top_page_o),
    .below_top_page_i(below_top_page_o), .read_page_i(read_page_o),
    .read_history_i(read_history_o), .fail_count_o(fail_count), .pending_o(pending),
    .results_o(results)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("view_history_stack: mismatch");
      $finish;
    end
  end

  // drive one request and hold it until accepted
  task automatic send_request(logic [3:0] kind, logic [PageW-1:0] pg, logic keep,
                              logic jok, logic [7:0] mask, logic [IdxW-1:0] ridx);
    start_i         <= 1'b1;
    req_type_i      <= kind;
    page_id_i       <= pg;
    keep_top_i      <= keep;
    jump_ok_i       <= jok;
    outranks_mask_i <= mask;
    read_index_i    <= ridx;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // mostly reuse a small pool so pops, go back and delete find matches
  function automatic logic [PageW-1:0] pick_page();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PageW'($urandom);
      default: return recent_pages[$urandom_range(0, 7)];
    endcase
  endfunction

  initial begin
    int burst;
    logic [3:0] kind;
    for (int i = 0; i < 8; i++) recent_pages[i] = PageW'(i * 16'h1111 + 1);
    recent_pages[7] = 16'hffff;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty stack, zero page, bad codes, fill, overflow, each request
    send_request(REQ_POP, 16'h0001, 0, 1, 8'h00, 3'd0);
    send_request(REQ_RESET, 16'h0001, 1, 1, 8'h00, 3'd0);
    send_request(REQ_PUSH, 16'h0000, 0, 1, 8'h00, 3'd0);
    send_request(4'd15, 16'hffff, 1, 1, 8'hff, 3'd7);
    send_request(4'd10, 16'h1234, 0, 0, 8'h00, 3'd0);
    send_request(REQ_RESET, 16'hffff, 0, 0, 8'h00, 3'd0);
    send_request(REQ_RESET, 16'hffff, 0, 1, 8'h00, 3'd0);
    send_request(REQ_DELETE, 16'h0000, 0, 1, 8'h00, 3'd0);
    for (int i = 1; i < 8; i++)
      send_request(REQ_PUSH, recent_pages[i], 0, 1, 8'h00, 3'd0);
    send_request(REQ_ADD, 16'h0101, 0, 1, 8'h00, 3'd0);
    send_request(REQ_PRIO, 16'h0101, 0, 1, 8'hff, 3'd0);
    send_request(REQ_READ, 16'h0000, 0, 0, 8'h00, 3'd7);
    send_request(REQ_POP, 16'h0202, 0, 1, 8'h00, 3'd0);
    send_request(REQ_POP, recent_pages[6], 0, 1, 8'h00, 3'd0);
    send_request(REQ_PRIO, 16'h0303, 0, 1, 8'hff, 3'd0);
    send_request(REQ_PRIO, 16'h0303, 0, 1, 8'hf0, 3'd0);
    send_request(REQ_BACK, 16'hbeef, 0, 1, 8'h00, 3'd0);
    send_request(REQ_BACK, recent_pages[3], 0, 0, 8'h00, 3'd0);
    send_request(REQ_DELETE, recent_pages[2], 0, 1, 8'h00, 3'd0);
    send_request(REQ_ADD, 16'h8000, 1, 1, 8'h00, 3'd0);
    send_request(REQ_COVER, 16'h7fff, 0, 1, 8'h00, 3'd1);
    send_request(REQ_REPLACE, 16'h00aa, 0, 0, 8'h00, 3'd0);
    send_request(REQ_BACK, recent_pages[1], 0, 1, 8'h00, 3'd0);
    send_request(REQ_DELETE, 16'h0000, 0, 1, 8'h00, 3'd0);
    send_request(REQ_READ, 16'h0000, 0, 0, 8'h00, 3'd0);

    while (requests_sent < 1525) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) begin
        case ($urandom_range(0, 19))
          0:       kind = 4'($urandom_range(10, 15));
          1, 2:    kind = REQ_READ;
          3:       kind = REQ_RESET;
          default: kind = 4'($urandom_range(0, 8));
        endcase
        send_request(kind, pick_page(), 1'($urandom), $urandom_range(0, 5) != 0,
                     8'($urandom), 3'($urandom));
        if ($urandom_range(0, 7) == 0) recent_pages[$urandom_range(0, 7)] = PageW'($urandom);
      end
      idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30));
    end
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("sent %0d requests, checked %0d results over %0d cycles",
             requests_sent, results, cycle_count);
    if (fail_count == 0) $display("view_history_stack: match");
    else $display("view_history_stack: mismatch");
    $finish;
  end

endmodule
